// ===== design/dcram_pkg.sv =====
package dcram_pkg;

  localparam int unsigned DEF_PAGE_COUNT   = 8;
  localparam int unsigned DEF_COLUMN_COUNT = 128;
  localparam int unsigned RECIP_SCALE      = 65536;

  localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [1:0] MODE_PAGE       = 2'd2;
  localparam logic [1:0] MODE_INVALID    = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  localparam logic [7:0] CMD_COL_HIGH_LAST = 8'h1F;
  localparam logic [7:0] CMD_COL_HIGH_BASE = 8'h10;
  localparam logic [7:0] CMD_PAGE_BASE     = 8'hB0;
  localparam logic [7:0] CMD_NORMAL        = 8'hA6;
  localparam logic [7:0] CMD_INVERT        = 8'hA7;
  localparam logic [7:0] CMD_OFF           = 8'hAE;
  localparam logic [7:0] CMD_ON            = 8'hAF;
  localparam logic [7:0] CMD_REMAP_ZERO    = 8'hA0;
  localparam logic [7:0] CMD_REMAP_END     = 8'hA1;
  localparam logic [7:0] CMD_SCAN_NORMAL   = 8'hC0;
  localparam logic [7:0] CMD_SCAN_REMAP    = 8'hC8;
  localparam logic [7:0] CMD_SCROLL_OFF    = 8'h2E;
  localparam logic [7:0] CMD_SCROLL_ON     = 8'h2F;
  localparam logic [7:0] CMD_RAM_RESUME    = 8'hA4;
  localparam logic [7:0] CMD_CONTRAST      = 8'h81;
  localparam logic [7:0] CMD_CHARGE_PUMP   = 8'h8D;
  localparam logic [7:0] CMD_CLOCK_DIV     = 8'hD5;
  localparam logic [7:0] CMD_MUX_RATIO     = 8'hA8;
  localparam logic [7:0] CMD_DISP_OFFSET   = 8'hD3;
  localparam logic [7:0] CMD_MODE          = 8'h20;
  localparam logic [7:0] CMD_START_LINE    = 8'h40;
  localparam logic [7:0] CMD_COM_PINS      = 8'hDA;
  localparam logic [7:0] CMD_PRECHARGE     = 8'hD9;
  localparam logic [7:0] CMD_VCOM_DESELECT = 8'hDB;
  localparam logic [7:0] CMD_COL_WINDOW    = 8'h21;
  localparam logic [7:0] CMD_PAGE_WINDOW   = 8'h22;
  localparam logic [7:0] CMD_VSCROLL_AREA  = 8'hA3;
  localparam logic [7:0] CMD_HSCROLL_R     = 8'h26;
  localparam logic [7:0] CMD_HSCROLL_L     = 8'h27;
  localparam logic [7:0] CMD_VHSCROLL_R    = 8'h29;
  localparam logic [7:0] CMD_VHSCROLL_L    = 8'h2A;

  localparam logic [7:0] NIBBLE_HIGH_MASK = 8'hF0;
  localparam logic [7:0] NIBBLE_LOW_MASK  = 8'h0F;
  localparam logic [7:0] CONTRAST_RESET   = 8'h7F;
  localparam logic [7:0] MODE_LAST_VALID  = 8'd2;

  typedef struct packed {
    logic       cmd;
    logic       deselected;
    logic       is_data;
    logic [7:0] data_byte;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ram_written;
    logic [2:0] cursor_page_now;
    logic [6:0] cursor_column_now;
    logic [7:0] contrast_now;
    logic [1:0] addressing_now;
    logic       panel_on;
    logic       panel_inverted;
    logic       segment_remap_zero;
    logic       com_scan_normal;
    logic       view_changed;
    logic [1:0] status;
  } rsp_t;

  // remainder of a byte by a constant, quotient from the scaled reciprocal
  function automatic logic [7:0] mod_by(input logic [7:0] v, input logic [8:0] m,
                                        input logic [16:0] recip);
    logic [24:0] prod;
    logic [16:0] quot_m;
    logic [16:0] rem;
    prod   = 25'(v) * 25'(recip);
    quot_m = 17'(prod[23:16]) * 17'(m);
    rem    = 17'(v) - quot_m;
    return rem[7:0];
  endfunction

endpackage

// ===== design/display_controller_cmd_ram_unit.sv =====
// latency: each accepted item passes the s1 stage register, then the result queue, before its result can be taken
// throughput: one item per cycle while req_ready is high, at most one access per item on the single display RAM port
// a three-entry result queue; req_ready drops once three results are waiting or in flight
// reset: synchronous; afterwards a clearing pass writes zero to all
// PAGE_COUNT * COLUMN_COUNT RAM bytes, with req_ready low meanwhile
module display_controller_cmd_ram_unit
  import dcram_pkg::*;
#(
  parameter int unsigned PAGE_COUNT   = DEF_PAGE_COUNT,
  parameter int unsigned COLUMN_COUNT = DEF_COLUMN_COUNT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned RAM_DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int unsigned AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned CW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned QW = 2;
  localparam int unsigned PAGE_RECIP = (RECIP_SCALE + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam int unsigned COL_RECIP  = (RECIP_SCALE + COLUMN_COUNT - 1) / COLUMN_COUNT;

  logic [7:0] ram [RAM_DEPTH];
  logic [7:0] ram_q;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic [PW-1:0] cur_page, cur_page_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [PW-1:0] win_sp, win_sp_next, win_ep, win_ep_next;
  logic [CW-1:0] win_sc, win_sc_next, win_ec, win_ec_next;
  logic [1:0]    addressing, addressing_next;
  logic [7:0]    pending, pending_next;
  logic [2:0]    bytes_left, bytes_left_next;
  logic [7:0]    contrast, contrast_next;
  logic          flag_on, flag_on_next, flag_inv, flag_inv_next;
  logic          flag_remap, flag_remap_next, flag_scan, flag_scan_next;

  logic          acc;
  logic          do_write, do_read, rd_ok, chg;
  logic [1:0]    st;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW:0]   col_inc;
  logic [PW:0]   page_inc;
  logic [7:0]    v, nib_col;
  logic          first;

  logic          s1_valid, s1_rd;
  rsp_t          s1_res, s1_res_next, push_res;

  rsp_t          queue [Q_DEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr, q_count;
  logic          pop;

  assign req_ready = !clr_busy && ((3'(q_count) + 3'(s1_valid)) < 3'(Q_DEPTH));
  assign acc       = req_valid && req_ready;
  assign v         = req.data_byte;
  assign col_inc   = {1'b0, cur_col} + (CW+1)'(1);
  assign page_inc  = {1'b0, cur_page} + (PW+1)'(1);
  assign first     = (bytes_left == 3'd2);
  assign wr_addr   = AW'(32'(cur_page) * 32'(COLUMN_COUNT) + 32'(cur_col));
  assign rd_addr   = AW'(32'(req.read_page) * 32'(COLUMN_COUNT) + 32'(req.read_column));
  assign rd_ok     = (32'(req.read_page) < 32'(PAGE_COUNT)) &&
                     (32'(req.read_column) < 32'(COLUMN_COUNT));

  always_comb begin
    cur_page_next   = cur_page;
    cur_col_next    = cur_col;
    win_sp_next     = win_sp;
    win_ep_next     = win_ep;
    win_sc_next     = win_sc;
    win_ec_next     = win_ec;
    addressing_next = addressing;
    pending_next    = pending;
    bytes_left_next = bytes_left;
    contrast_next   = contrast;
    flag_on_next    = flag_on;
    flag_inv_next   = flag_inv;
    flag_remap_next = flag_remap;
    flag_scan_next  = flag_scan;
    do_write        = 1'b0;
    do_read         = 1'b0;
    chg             = 1'b0;
    st              = STATUS_OK;
    nib_col         = 8'(cur_col);
    if (req.cmd) begin
      do_read = 1'b1;
    end else if (req.deselected) begin
      st = STATUS_IGNORED;
    end else if (req.is_data) begin
      do_write = 1'b1;
      chg      = 1'b1;
      case (addressing)
        MODE_HORIZONTAL: begin
          if (col_inc > {1'b0, win_ec}) begin
            cur_col_next = win_sc;
            if (page_inc > {1'b0, win_ep}) begin
              cur_page_next = win_sp;
            end else begin
              cur_page_next = page_inc[PW-1:0];
            end
          end else begin
            cur_col_next = col_inc[CW-1:0];
          end
        end
        MODE_VERTICAL: begin
          if (page_inc > {1'b0, win_ep}) begin
            cur_page_next = win_sp;
            if (col_inc > {1'b0, win_ec}) begin
              cur_col_next = win_sc;
            end else begin
              cur_col_next = col_inc[CW-1:0];
            end
          end else begin
            cur_page_next = page_inc[PW-1:0];
          end
        end
        MODE_PAGE: begin
          if (col_inc >= (CW+1)'(COLUMN_COUNT)) begin
            cur_col_next = '0;
          end else begin
            cur_col_next = col_inc[CW-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (bytes_left == 3'd0) begin
      if (v >= CMD_PAGE_BASE && {1'b0, v} < 9'(32'(CMD_PAGE_BASE) + PAGE_COUNT)) begin
        cur_page_next = PW'(v - CMD_PAGE_BASE);
      end else if (v <= CMD_COL_HIGH_LAST) begin
        if (addressing == MODE_PAGE) begin
          if (v < CMD_COL_HIGH_BASE) begin
            nib_col = (8'(cur_col) & NIBBLE_HIGH_MASK) | (v & NIBBLE_LOW_MASK);
          end else begin
            nib_col = (8'(cur_col) & NIBBLE_LOW_MASK) | ((v & NIBBLE_LOW_MASK) << 4);
          end
          cur_col_next = CW'(mod_by(nib_col, 9'(COLUMN_COUNT), 17'(COL_RECIP)));
        end
      end else begin
        unique case (v) inside
          CMD_NORMAL: begin
            flag_inv_next = 1'b0;
            chg           = 1'b1;
          end
          CMD_INVERT: begin
            flag_inv_next = 1'b1;
            chg           = 1'b1;
          end
          CMD_OFF: begin
            flag_on_next = 1'b0;
            chg          = 1'b1;
          end
          CMD_ON: begin
            flag_on_next = 1'b1;
            chg          = 1'b1;
          end
          CMD_REMAP_ZERO:  flag_remap_next = 1'b1;
          CMD_REMAP_END:   flag_remap_next = 1'b0;
          CMD_SCAN_NORMAL: flag_scan_next  = 1'b1;
          CMD_SCAN_REMAP:  flag_scan_next  = 1'b0;
          CMD_SCROLL_OFF, CMD_SCROLL_ON, CMD_RAM_RESUME: begin
          end
          CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_CLOCK_DIV, CMD_MUX_RATIO, CMD_DISP_OFFSET,
          CMD_MODE, CMD_START_LINE, CMD_COM_PINS, CMD_PRECHARGE, CMD_VCOM_DESELECT: begin
            pending_next    = v;
            bytes_left_next = 3'd1;
          end
          CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA: begin
            pending_next    = v;
            bytes_left_next = 3'd2;
          end
          CMD_HSCROLL_R, CMD_HSCROLL_L: begin
            pending_next    = v;
            bytes_left_next = 3'd6;
          end
          CMD_VHSCROLL_R, CMD_VHSCROLL_L: begin
            pending_next    = v;
            bytes_left_next = 3'd5;
          end
          default: st = STATUS_UNKNOWN;
        endcase
      end
    end else begin
      case (pending)
        CMD_CONTRAST: begin
          contrast_next = v;
          chg           = 1'b1;
        end
        CMD_MODE: begin
          if (v > MODE_LAST_VALID) begin
            addressing_next = MODE_INVALID;
            st              = STATUS_UNKNOWN;
          end else begin
            addressing_next = v[1:0];
          end
        end
        CMD_PAGE_WINDOW: begin
          if (first) begin
            cur_page_next = PW'(mod_by(v, 9'(PAGE_COUNT), 17'(PAGE_RECIP)));
            win_sp_next   = PW'(mod_by(v, 9'(PAGE_COUNT), 17'(PAGE_RECIP)));
          end else begin
            win_ep_next = PW'(mod_by(v, 9'(PAGE_COUNT), 17'(PAGE_RECIP)));
          end
        end
        CMD_COL_WINDOW: begin
          if (first) begin
            cur_col_next = CW'(mod_by(v, 9'(COLUMN_COUNT), 17'(COL_RECIP)));
            win_sc_next  = CW'(mod_by(v, 9'(COLUMN_COUNT), 17'(COL_RECIP)));
          end else begin
            win_ec_next = CW'(mod_by(v, 9'(COLUMN_COUNT), 17'(COL_RECIP)));
          end
        end
        default: begin
        end
      endcase
      bytes_left_next = bytes_left - 3'd1;
      if (bytes_left == 3'd1) begin
        pending_next = '0;
      end
    end
  end

  always_comb begin
    s1_res_next                    = '0;
    s1_res_next.ram_written        = do_write;
    s1_res_next.cursor_page_now    = 3'(cur_page_next);
    s1_res_next.cursor_column_now  = 7'(cur_col_next);
    s1_res_next.contrast_now       = contrast_next;
    s1_res_next.addressing_now     = addressing_next;
    s1_res_next.panel_on           = flag_on_next;
    s1_res_next.panel_inverted     = flag_inv_next;
    s1_res_next.segment_remap_zero = flag_remap_next;
    s1_res_next.com_scan_normal    = flag_scan_next;
    s1_res_next.view_changed       = chg;
    s1_res_next.status             = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_page   <= '0;
      cur_col    <= '0;
      win_sp     <= '0;
      win_ep     <= PW'(PAGE_COUNT - 1);
      win_sc     <= '0;
      win_ec     <= CW'(COLUMN_COUNT - 1);
      addressing <= MODE_PAGE;
      pending    <= '0;
      bytes_left <= '0;
      contrast   <= CONTRAST_RESET;
      flag_on    <= 1'b0;
      flag_inv   <= 1'b0;
      flag_remap <= 1'b1;
      flag_scan  <= 1'b1;
    end else if (acc) begin
      cur_page   <= cur_page_next;
      cur_col    <= cur_col_next;
      win_sp     <= win_sp_next;
      win_ep     <= win_ep_next;
      win_sc     <= win_sc_next;
      win_ec     <= win_ec_next;
      addressing <= addressing_next;
      pending    <= pending_next;
      bytes_left <= bytes_left_next;
      contrast   <= contrast_next;
      flag_on    <= flag_on_next;
      flag_inv   <= flag_inv_next;
      flag_remap <= flag_remap_next;
      flag_scan  <= flag_scan_next;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(RAM_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      ram[clr_addr] <= '0;
    end else if (acc && do_write) begin
      ram[wr_addr] <= v;
    end
    if (acc && do_read && rd_ok) begin
      ram_q <= ram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res <= s1_res_next;
      s1_rd  <= do_read && rd_ok;
    end
  end

  always_comb begin
    push_res           = s1_res;
    push_res.read_data = s1_rd ? ram_q : 8'd0;
  end

  // result queue
  assign rsp_valid = (q_count != '0);
  assign pop       = rsp_valid && rsp_ready;
  assign rsp       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == QW'(Q_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(Q_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      q_count <= q_count + QW'(s1_valid) - QW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      queue[wr_ptr] <= push_res;
    end
  end

`ifndef SYNTHESIS
  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> s1_valid)
    else $error("accepted item did not reach the result stage");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count != QW'(Q_DEPTH)))
    else $error("result queue full while a result is pushed");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> ($past(clr_addr) == AW'(RAM_DEPTH - 1)))
    else $error("clearing pass ended early");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !(req_valid && req_ready))
    else $error("item accepted during clearing pass");
`endif

endmodule
